>>> hdl/fwbp_pkg.sv
`timescale 1ns / 1ps
// Shared constants and helpers for the fixed-width bit packer.
// Depends on nothing; used by hdl/fixed_width_bit_packer.sv.
package fwbp_pkg;

	localparam int CODE_WIDTH_DEF = 32;
	localparam int CODE_WIDTH_MAX = 57;
	localparam int BYTE_W         = 8;
	localparam int BITLEN_W       = $clog2(CODE_WIDTH_MAX + 1);

	// register indexes on the configuration port
	localparam logic REG_MAX_CODE    = 1'b0;
	localparam logic REG_NAN_MARKING = 1'b1;

	// position of the highest set bit plus one; zero for zero
	function automatic logic [BITLEN_W-1:0] bit_length(input logic [63:0] v);
		logic [BITLEN_W-1:0] n;
		n = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				n = BITLEN_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

>>> hdl/fixed_width_bit_packer.sv
`timescale 1ns / 1ps
// Fixed-width LSB-first bit packer: codes in, packed bytes out.
// Depends on hdl/fwbp_pkg.sv.
//
// Usage:
//   Code channel: code and final_req, qualified by code_valid; the block holds
//   code_stall high while it cannot take a word. Each code is clamped against
//   max_code (plus one with nan_marking), cut to the code width (bit length of
//   max_code) and appended LSB first behind the pending bits.
//   Byte channel: packed_byte and end_of_stream, qualified by byte_valid; the
//   receiver holds byte_stall high to hold a word on the port.
//   Path: an accepted code passes the input register, the byte buffer and
//   the output register in that order. Throughput: one byte per cycle while
//   the receiver does not stall, set by the single byte output register; the
//   buffer takes the next code only when empty or handing out its last byte.
//   A final code flushes the partial byte zero-padded and marks the last byte
//   with end_of_stream; the next array starts on a byte boundary.
//   Reset clears the configuration (max_code 0, no NaN marking), the pending
//   bits and all queued bytes. While the receiver stalls, bytes wait in the
//   output register and the byte buffer, then the code register fills and
//   code_stall rises. Write configuration only while the block is idle.
module fixed_width_bit_packer #(
	parameter int CODE_WIDTH = fwbp_pkg::CODE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [((CODE_WIDTH > 32) ? 4 : 3)-1:0] paddr,
	input  logic [((CODE_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
	output logic [((CODE_WIDTH > 32) ? 64 : 32)-1:0] prdata,
	output logic                  pready,
	// code channel
	input  logic                  code_valid,
	output logic                  code_stall,
	input  logic [CODE_WIDTH-1:0] code,
	input  logic                  final_req,
	// byte channel
	output logic                  byte_valid,
	input  logic                  byte_stall,
	output logic [7:0]            packed_byte,
	output logic                  end_of_stream
);

	localparam int PDATA_W = (CODE_WIDTH > 32) ? 64 : 32;
	localparam int ADDR_W  = (CODE_WIDTH > 32) ? 4 : 3;
	localparam int W_W     = $clog2(CODE_WIDTH + 1);
	localparam int ACC_W   = CODE_WIDTH + 7;
	localparam int TOT_W   = $clog2(ACC_W + 1);
	localparam int NB_MAX  = (ACC_W + 7) / 8;
	localparam int NB_W    = $clog2(NB_MAX + 1);
	localparam int BUF_W   = NB_MAX * fwbp_pkg::BYTE_W;
	localparam int PAD_W   = BUF_W + fwbp_pkg::BYTE_W;
	localparam int FULL_W  = TOT_W - 3;

	// configuration registers and values derived at write time
	logic [CODE_WIDTH-1:0] max_code_q;
	logic                  nan_q;
	logic [W_W-1:0]        bitlen_q;
	logic [CODE_WIDTH:0]   limit_q;

	// input register
	logic                  valid_s1;
	logic [CODE_WIDTH-1:0] code_s1;
	logic                  final_s1;

	// pending bits of the unfinished byte
	logic [6:0]            residual_bits_q;
	logic [2:0]            residual_count_q;

	// completed bytes waiting for the output register
	logic [BUF_W-1:0]      buf_q;
	logic [NB_W-1:0]       nbytes_q;
	logic                  fin_q;

	// output register
	logic                  byte_valid_q;
	logic [7:0]            packed_byte_q;
	logic                  eos_q;

	logic                  cfg_wr;
	logic                  reg_idx;
	logic                  out_free;
	logic                  pop;
	logic                  merge;
	logic [W_W-1:0]        width_d;
	logic [CODE_WIDTH-1:0] wmask_d;
	logic [CODE_WIDTH-1:0] value_d;
	logic [PAD_W-1:0]      acc_d;
	logic [TOT_W-1:0]      total_d;
	logic [FULL_W-1:0]     full_d;
	logic [NB_W-1:0]       nbytes_d;
	logic [6:0]            resid_sel_d;

	// ---------------------------------------------------------------------
	// Configuration port: a write lands on the access cycle
	// ---------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1];

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			fwbp_pkg::REG_MAX_CODE:    prdata = PDATA_W'(max_code_q);
			fwbp_pkg::REG_NAN_MARKING: prdata = PDATA_W'(nan_q);
			default:                   prdata = '0;
		endcase
	end

	// Keep bit length and range limit ready so the data path sees no search.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_code_q <= '0;
			nan_q      <= 1'b0;
			bitlen_q   <= '0;
			limit_q    <= '0;
		end else if (cfg_wr) begin
			if (reg_idx == fwbp_pkg::REG_MAX_CODE) begin
				max_code_q <= pwdata[CODE_WIDTH-1:0];
				bitlen_q   <= W_W'(fwbp_pkg::bit_length(64'(pwdata[CODE_WIDTH-1:0])));
				limit_q    <= {1'b0, pwdata[CODE_WIDTH-1:0]} + (CODE_WIDTH+1)'(nan_q);
			end else begin
				nan_q   <= pwdata[0];
				limit_q <= {1'b0, max_code_q} + (CODE_WIDTH+1)'(pwdata[0]);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Handshakes
	// ---------------------------------------------------------------------
	assign out_free   = !byte_valid_q || !byte_stall;
	assign pop        = (nbytes_q != '0) && out_free;
	// The buffer takes a new code when it is empty or hands out its last byte.
	assign merge      = valid_s1 && ((nbytes_q == '0) || ((nbytes_q == NB_W'(1)) && pop));
	assign code_stall = valid_s1 && !merge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!code_stall) begin
			valid_s1 <= code_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (code_valid && !code_stall) begin
			code_s1  <= code;
			final_s1 <= final_req;
		end
	end

	// ---------------------------------------------------------------------
	// Packing: clamp, mask, append behind the pending bits, split into bytes
	// ---------------------------------------------------------------------
	always_comb begin
		// zero max_code: one bit with NaN marking, none without
		width_d = (bitlen_q == '0) ? W_W'(nan_q) : bitlen_q;
		for (int i = 0; i < CODE_WIDTH; i++) begin
			wmask_d[i] = (i < int'(width_d));
		end
		if ({1'b0, code_s1} > limit_q) begin
			value_d = nan_q ? wmask_d : '0;
		end else begin
			value_d = code_s1 & wmask_d;
		end
		acc_d       = PAD_W'(residual_bits_q) | (PAD_W'(value_d) << residual_count_q);
		total_d     = TOT_W'(residual_count_q) + TOT_W'(width_d);
		full_d      = total_d[TOT_W-1:3];
		nbytes_d    = NB_W'(full_d) + NB_W'(final_s1 && (total_d[2:0] != 3'd0));
		resid_sel_d = acc_d[{full_d, 3'b000} +: 7];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			residual_bits_q  <= '0;
			residual_count_q <= '0;
			nbytes_q         <= '0;
			fin_q            <= 1'b0;
		end else if (merge) begin
			// drop pending bits after a final code: next array is byte aligned
			residual_bits_q  <= final_s1 ? 7'd0 : resid_sel_d;
			residual_count_q <= final_s1 ? 3'd0 : total_d[2:0];
			nbytes_q         <= nbytes_d;
			fin_q            <= final_s1;
		end else if (pop) begin
			nbytes_q <= nbytes_q - NB_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (merge) begin
			buf_q <= acc_d[BUF_W-1:0];
		end else if (pop) begin
			buf_q <= buf_q >> fwbp_pkg::BYTE_W;
		end
	end

	// ---------------------------------------------------------------------
	// Output register: advance one byte whenever it is empty or the receiver takes the word
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_q <= 1'b0;
		end else if (out_free) begin
			byte_valid_q <= (nbytes_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			packed_byte_q <= buf_q[7:0];
			eos_q         <= fin_q && (nbytes_q == NB_W'(1));
		end
	end

	assign byte_valid    = byte_valid_q;
	assign packed_byte   = packed_byte_q;
	assign end_of_stream = eos_q;

endmodule

>>> bench/fixed_width_bit_packer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the fixed-width LSB-first bit packer: codes in, bytes out.
// Depends on hdl/fwbp_pkg.sv and hdl/fixed_width_bit_packer.sv; reads no files.
module fixed_width_bit_packer_tb;

	localparam int CW = fwbp_pkg::CODE_WIDTH_DEF;

	// byte address of each register: index times four
	localparam logic [2:0] MAX_CODE_ADDR = {fwbp_pkg::REG_MAX_CODE, 2'b00};
	localparam logic [2:0] NAN_MARK_ADDR = {fwbp_pkg::REG_NAN_MARKING, 2'b00};

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} stream_byte_t;

	// Bit-accurate packer model plus the queue of bytes it still owes the port.
	class byte_stream_sb;
		logic [CW-1:0] max_code;
		logic          nan_on;
		logic [6:0]    pend_bits;
		logic [2:0]    pend_cnt;
		stream_byte_t  due_bytes[$];
		int            n_errors;

		function new();
			max_code  = '0;
			nan_on    = 1'b0;
			pend_bits = '0;
			pend_cnt  = '0;
			n_errors  = 0;
		endfunction

		// Pack one accepted code and queue the bytes it completes.
		function void pack_code(logic [CW-1:0] c, logic fin);
			int unsigned   w;
			int unsigned   cnt;
			logic [CW-1:0] wmask;
			logic [CW:0]   limit;
			logic [CW-1:0] val;
			logic [63:0]   acc;
			logic [7:0]    made[$];
			stream_byte_t  sb_item;
			w = 0;
			for (int i = 0; i < CW; i++) begin
				if (max_code[i]) begin
					w = i + 1;
				end
			end
			if (max_code == '0) begin
				w = nan_on ? 1 : 0;
			end
			wmask = (w == 0) ? '0 : ({CW{1'b1}} >> (CW - w));
			// one extra code is in range when NaN marking is on
			limit = {1'b0, max_code} + nan_on;
			if ({1'b0, c} > limit) begin
				val = nan_on ? wmask : '0;
			end else begin
				val = c & wmask;
			end
			cnt = pend_cnt;
			acc = {57'b0, pend_bits} | ({{(64-CW){1'b0}}, val} << cnt);
			cnt += w;
			while (cnt >= 8) begin
				made.push_back(acc[7:0]);
				acc = acc >> 8;
				cnt -= 8;
			end
			if (fin) begin
				if (cnt > 0) begin
					made.push_back(acc[7:0]);
				end
				pend_bits = '0;
				pend_cnt  = '0;
			end else begin
				pend_bits = acc[6:0];
				pend_cnt  = cnt[2:0];
			end
			foreach (made[k]) begin
				sb_item.data = made[k];
				sb_item.last = fin && (k == made.size() - 1);
				due_bytes.push_back(sb_item);
			end
		endfunction

		// Compare one byte taken from the port with the oldest one owed.
		function void match_byte(logic [7:0] b, logic eos);
			stream_byte_t want;
			if (due_bytes.size() == 0) begin
				$error("packed_byte: expected none, actual %02h", b);
				n_errors++;
				return;
			end
			want = due_bytes.pop_front();
			if (b !== want.data) begin
				$error("packed_byte: expected %02h, actual %02h", want.data, b);
				n_errors++;
			end
			if (eos !== want.last) begin
				$error("end_of_stream: expected %0b, actual %0b", want.last, eos);
				n_errors++;
			end
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [2:0]    paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;
	logic          code_valid;
	logic          code_stall;
	logic [CW-1:0] code;
	logic          final_req;
	logic          byte_valid;
	logic          byte_stall;
	logic [7:0]    packed_byte;
	logic          end_of_stream;

	// traffic shaping flags for the code sender and the byte receiver
	logic steady_tx;
	logic steady_rx;
	logic hold_off;

	byte_stream_sb sb = new();

	fixed_width_bit_packer #(.CODE_WIDTH(CW)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.code_valid    (code_valid),
		.code_stall    (code_stall),
		.code          (code),
		.final_req     (final_req),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.packed_byte   (packed_byte),
		.end_of_stream (end_of_stream)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sample the byte port at the edge; everything read here is the pre-edge value.
	always @(posedge clk) begin
		if (arst_n && byte_valid && !byte_stall) begin
			sb.match_byte(packed_byte, end_of_stream);
		end
	end

	// Byte receiver: stall about ten percent of the time, never in a steady stretch,
	// and hold off for a long count when asked so the packer backs up into its input.
	initial begin
		byte_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				byte_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
				byte_stall <= 1'b0;
			end else begin
				byte_stall <= !steady_rx && ($urandom_range(0, 99) < 10);
			end
		end
	end

	// Write one register: setup cycle, then access cycle until pready, then idle.
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid and hold until every owed byte is out, then let the pipe settle,
	// since a code of zero width may still be in flight with nothing owed.
	task automatic wait_drain();
		code_valid <= 1'b0;
		do @(posedge clk); while (sb.due_bytes.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// Reconfigure only from an idle block; pending bits carry over.
	task automatic set_config(input logic [CW-1:0] maxc, input logic nan);
		wait_drain();
		write_reg(MAX_CODE_ADDR, maxc);
		write_reg(NAN_MARK_ADDR, {31'b0, nan});
		sb.max_code = maxc;
		sb.nan_on   = nan;
	endtask

	// Offer one word and hold it until accepted; then, outside steady runs, sometimes idle for a random pause.
	task automatic send_code(input logic [CW-1:0] c, input logic fin);
		code_valid <= 1'b1;
		code       <= c;
		final_req  <= fin;
		do @(posedge clk); while (code_stall);
		sb.pack_code(c, fin);
		if (!steady_tx && $urandom_range(0, 99) < 10) begin
			code_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Bias codes towards the edges of the valid range.
	function automatic logic [CW-1:0] pick_code(input logic [CW-1:0] maxc);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom_range(0, maxc);
			5:             return maxc + 1;
			6:             return maxc;
			7:             return $urandom_range(0, 1) ? '1 : '0;
			default:       return $urandom;
		endcase
	endfunction

	initial begin
		logic [CW-1:0] maxc;
		logic          nan;
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		code_valid = 1'b0;
		code       = '0;
		final_req  = 1'b0;
		steady_tx  = 1'b0;
		steady_rx  = 1'b0;
		hold_off   = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero width straight out of reset: nothing packed, a final code flushes nothing.
		send_code('1, 1'b1);
		send_code('0, 1'b0);
		send_code(32'h1234_5678, 1'b1);

		// One-bit codes with NaN marking; two is past max+1 and turns into the NaN code.
		set_config('0, 1'b1);
		send_code(0, 1'b0);
		send_code(1, 1'b0);
		send_code(2, 1'b0);
		send_code('1, 1'b1);

		// Three-bit codes: max+1 still fits, anything above becomes all ones.
		set_config(5, 1'b1);
		send_code(6, 1'b0);
		send_code(7, 1'b0);
		send_code(5, 1'b0);
		send_code(0, 1'b1);

		// max+1 needs a ninth bit here; only the low eight are packed.
		set_config(255, 1'b1);
		send_code(256, 1'b0);
		send_code(300, 1'b0);
		send_code(255, 1'b1);

		// Full-width codes without marking: every value is in range.
		set_config('1, 1'b0);
		send_code('1, 1'b0);
		send_code('0, 1'b0);
		send_code(32'h1234_5678, 1'b1);

		// Change width mid-array: leave three bits pending across the write.
		set_config(7, 1'b0);
		send_code(3, 1'b0);
		set_config(1000, 1'b0);
		send_code(1001, 1'b0);
		send_code(1000, 1'b1);

		// Random phases, each on its own setting; extremes first.
		for (int p = 0; p < 10; p++) begin
			case (p)
				0:       begin maxc = '0; nan = 1'b1; end
				1:       begin maxc = '1; nan = 1'b1; end
				2:       begin maxc = '1; nan = 1'b0; end
				3:       begin maxc = 1;  nan = 1'b0; end
				default: begin
					maxc = CW'($urandom) >> $urandom_range(0, CW - 1);
					nan  = 1'($urandom_range(0, 1));
				end
			endcase
			set_config(maxc, nan);
			// one phase runs flat out on both sides
			steady_tx = (p == 4);
			steady_rx = (p == 4);
			for (int k = 0; k < 30; k++) begin
				send_code(pick_code(maxc), $urandom_range(0, 7) == 0);
			end
		end
		steady_tx = 1'b0;
		steady_rx = 1'b0;

		// Back-pressure: the receiver holds off while four-byte codes keep coming,
		// so the byte buffer fills and the code port stalls.
		set_config('1, 1'b0);
		hold_off = 1'b1;
		steady_tx = 1'b1;
		for (int k = 0; k < 30; k++) begin
			send_code($urandom, k == 29);
		end
		steady_tx = 1'b0;

		wait_drain();
		repeat (20) @(posedge clk);
		if (sb.n_errors == 0 && sb.due_bytes.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
hdl/fwbp_pkg.sv
hdl/fixed_width_bit_packer.sv
bench/fixed_width_bit_packer_tb.sv
